// ===== rtl/core/bie_pkg.sv =====
// Shared types, codes and helpers for the Boolean expression evaluator.
`timescale 1ns / 1ps
`default_nettype none
package bie_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int OP_W = 3;

  // operator codes held on the operator stack
  localparam logic [OP_W-1:0] OP_OPEN = 3'd0;
  localparam logic [OP_W-1:0] OP_NOT  = 3'd1;
  localparam logic [OP_W-1:0] OP_AND  = 3'd2;
  localparam logic [OP_W-1:0] OP_OR   = 3'd3;
  localparam logic [OP_W-1:0] OP_IMP  = 3'd4;
  localparam logic [OP_W-1:0] OP_EQV  = 3'd5;

  // stack commands
  localparam logic [2:0] STK_HOLD    = 3'd0;
  localparam logic [2:0] STK_PUSH    = 3'd1;
  localparam logic [2:0] STK_POP     = 3'd2;
  localparam logic [2:0] STK_REPL    = 3'd3;
  localparam logic [2:0] STK_POPREPL = 3'd4;

  // result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNMATCHED = 2'd1;
  localparam logic [1:0] ST_MISSING   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // characters
  localparam logic [7:0] CH_A     = 8'd97;
  localparam logic [7:0] CH_Z     = 8'd122;
  localparam logic [7:0] CH_OPEN  = 8'd40;
  localparam logic [7:0] CH_CLOSE = 8'd41;
  localparam logic [7:0] CH_NOT   = 8'd33;
  localparam logic [7:0] CH_AND   = 8'd38;
  localparam logic [7:0] CH_OR    = 8'd124;
  localparam logic [7:0] CH_DASH  = 8'd45;
  localparam logic [7:0] CH_TILDE = 8'd126;

  typedef struct packed {
    logic [2:0]      op;
    logic [OP_W-1:0] data;
  } stk_cmd_t;

  // precedence plus one, so an open paren ranks lowest
  function automatic logic [2:0] prec(input logic [OP_W-1:0] op);
    logic [2:0] p;
    unique case (op) inside
      OP_NOT:         p = 3'd4;
      OP_AND:         p = 3'd3;
      OP_OR:          p = 3'd2;
      OP_IMP, OP_EQV: p = 3'd1;
      default:        p = 3'd0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bie_cell.sv =====
// One stack entry that shifts to or from its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module bie_cell #(
  parameter int W      = 1,
  parameter bit IS_TOP = 1'b0
) (
  input  wire logic             clk,
  input  wire bie_pkg::stk_cmd_t cmd,
  input  wire logic [W-1:0]     above,
  input  wire logic [W-1:0]     below,
  output logic      [W-1:0]     q
);

  logic [W-1:0] q_r;
  logic [W-1:0] q_nxt;

  always_comb begin
    unique case (cmd.op)
      bie_pkg::STK_PUSH:    q_nxt = IS_TOP ? cmd.data[W-1:0] : above;
      bie_pkg::STK_POP:     q_nxt = below;
      bie_pkg::STK_REPL:    q_nxt = IS_TOP ? cmd.data[W-1:0] : q_r;
      bie_pkg::STK_POPREPL: q_nxt = IS_TOP ? cmd.data[W-1:0] : below;
      default:              q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
`default_nettype wire

// ===== rtl/core/bie_stack.sv =====
// Stack built as a chain of shifting cells; entry 0 is the top.
`timescale 1ns / 1ps
`default_nettype none
module bie_stack #(
  parameter int DEPTH = bie_pkg::STACK_DEPTH_DEF,
  parameter int W     = 1
) (
  input  wire logic              clk,
  input  wire bie_pkg::stk_cmd_t cmd,
  output logic       [W-1:0]     top,
  output logic       [W-1:0]     second
);

  logic [W-1:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [W-1:0] above;
    logic [W-1:0] below;
    if (i == 0) begin : g_first
      assign above = '0;
    end else begin : g_mid
      assign above = q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below = q[i];
    end else begin : g_next
      assign below = q[i+1];
    end
    bie_cell #(
      .W      (W),
      .IS_TOP (i == 0)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .above (above),
      .below (below),
      .q     (q[i])
    );
  end

  assign top    = q[0];
  assign second = q[1];

endmodule
`default_nettype wire

// ===== rtl/core/boolean_infix_expression_evaluator.sv =====
// Top level: Boolean infix expression evaluator with operator and value stacks.
`timescale 1ns / 1ps
`default_nettype none
// Takes an infix Boolean expression one character per word (a..z, ( ) ! & | ~ and ->,
// other characters ignored) and returns one result word, value and status, after the
// word marked last. Variables read their truth value from cfg_data (bit 0 is a).
// A letter, '(', '!' or ignored character is handled when accepted; a binary operator
// pops and applies stacked operators of equal or higher precedence, then is pushed;
// ')' pops and applies down to its '(' and drops it; the last word pops every operator
// left and then emits the result. The operator stack pops and applies one operator per
// cycle. Both stacks are shift chains of STACK_DEPTH cells. A new word is accepted only
// between characters; a waiting result is held in the output register.
module boolean_infix_expression_evaluator #(
  parameter int STACK_DEPTH = bie_pkg::STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [25:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_value,
  output logic [1:0]       out_status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] TWO  = CW'(2);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_BIN   = 2'd1;
  localparam logic [1:0] S_CLOSE = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0]               st_r, st_nxt;
  logic [bie_pkg::OP_W-1:0] pend_r, pend_nxt;
  logic                     last_r, last_nxt;
  logic                     skip_r, skip_nxt;
  logic [1:0]               err_r, err_nxt;
  logic [CW-1:0]            op_cnt_r, op_cnt_nxt;
  logic [CW-1:0]            val_cnt_r, val_cnt_nxt;
  logic [25:0]              var_r;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_value_r, out_value_nxt;
  logic [1:0]               out_status_r, out_status_nxt;

  bie_pkg::stk_cmd_t        op_cmd, val_cmd;
  logic [bie_pkg::OP_W-1:0] top_op, second_op;
  logic                     v0, v1;

  logic                     op_push_en, op_pop_en;
  logic [bie_pkg::OP_W-1:0] op_push_code;
  logic                     lit_en, lit_val;
  logic                     apply_en;
  logic                     out_load;
  logic [1:0]               fsm_flag, op_flag, val_flag, flag;
  logic [7:0]               lit_off;
  logic                     l_bit, r_bit, res;

  bie_stack #(
    .DEPTH (STACK_DEPTH),
    .W     (bie_pkg::OP_W)
  ) u_op_stack (
    .clk    (clk),
    .cmd    (op_cmd),
    .top    (top_op),
    .second (second_op)
  );

  bie_stack #(
    .DEPTH (STACK_DEPTH),
    .W     (1)
  ) u_val_stack (
    .clk    (clk),
    .cmd    (val_cmd),
    .top    (v0),
    .second (v1)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (st_r == S_IDLE);
  assign lit_off   = in_ch - bie_pkg::CH_A;

  // sequencer
  always_comb begin
    st_nxt       = st_r;
    pend_nxt     = pend_r;
    last_nxt     = last_r;
    skip_nxt     = skip_r;
    op_push_en   = 1'b0;
    op_push_code = bie_pkg::OP_OPEN;
    op_pop_en    = 1'b0;
    lit_en       = 1'b0;
    lit_val      = 1'b0;
    apply_en     = 1'b0;
    out_load     = 1'b0;
    fsm_flag     = bie_pkg::ST_OK;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last;
          if (skip_r) begin
            skip_nxt = 1'b0;
          end else if (in_ch >= bie_pkg::CH_A && in_ch <= bie_pkg::CH_Z) begin
            lit_en  = 1'b1;
            lit_val = var_r[lit_off[4:0]];
          end else begin
            unique case (in_ch)
              bie_pkg::CH_OPEN: begin
                op_push_en   = 1'b1;
                op_push_code = bie_pkg::OP_OPEN;
              end
              bie_pkg::CH_NOT: begin
                op_push_en   = 1'b1;
                op_push_code = bie_pkg::OP_NOT;
              end
              bie_pkg::CH_CLOSE: st_nxt = S_CLOSE;
              bie_pkg::CH_AND: begin
                pend_nxt = bie_pkg::OP_AND;
                st_nxt   = S_BIN;
              end
              bie_pkg::CH_OR: begin
                pend_nxt = bie_pkg::OP_OR;
                st_nxt   = S_BIN;
              end
              bie_pkg::CH_TILDE: begin
                pend_nxt = bie_pkg::OP_EQV;
                st_nxt   = S_BIN;
              end
              bie_pkg::CH_DASH: begin
                pend_nxt = bie_pkg::OP_IMP;
                st_nxt   = S_BIN;
                skip_nxt = 1'b1;
              end
              default: ;
            endcase
          end
          if (in_last && st_nxt == S_IDLE) begin
            st_nxt = S_DRAIN;
          end
        end
      end
      S_BIN: begin
        if (op_cnt_r != '0 && bie_pkg::prec(top_op) >= bie_pkg::prec(pend_r)) begin
          apply_en  = 1'b1;
          op_pop_en = 1'b1;
        end else begin
          op_push_en   = 1'b1;
          op_push_code = pend_r;
          st_nxt       = last_r ? S_DRAIN : S_IDLE;
        end
      end
      S_CLOSE: begin
        if (op_cnt_r != '0 && top_op != bie_pkg::OP_OPEN) begin
          apply_en  = 1'b1;
          op_pop_en = 1'b1;
        end else begin
          if (op_cnt_r != '0) begin
            op_pop_en = 1'b1;
          end else begin
            fsm_flag = bie_pkg::ST_UNMATCHED;
          end
          st_nxt = last_r ? S_DRAIN : S_IDLE;
        end
      end
      S_DRAIN: begin
        if (op_cnt_r != '0) begin
          op_pop_en = 1'b1;
          apply_en  = (top_op != bie_pkg::OP_OPEN);
        end else if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // operator stack control
  always_comb begin
    op_cnt_nxt  = op_cnt_r;
    op_cmd.op   = bie_pkg::STK_HOLD;
    op_cmd.data = op_push_code;
    op_flag     = bie_pkg::ST_OK;
    if (op_push_en) begin
      if (op_cnt_r == FULL) begin
        op_flag = bie_pkg::ST_OVERFLOW;
      end else begin
        op_cmd.op  = bie_pkg::STK_PUSH;
        op_cnt_nxt = op_cnt_r + ONE;
      end
    end else if (op_pop_en) begin
      op_cmd.op  = bie_pkg::STK_POP;
      op_cnt_nxt = op_cnt_r - ONE;
    end
  end

  // value stack control and operator apply
  always_comb begin
    r_bit = (val_cnt_r != '0) ? v0 : 1'b0;
    l_bit = (val_cnt_r >= TWO) ? v1 : 1'b0;
    unique case (top_op)
      bie_pkg::OP_NOT: res = ~r_bit;
      bie_pkg::OP_AND: res = l_bit & r_bit;
      bie_pkg::OP_OR:  res = l_bit | r_bit;
      bie_pkg::OP_IMP: res = r_bit | ~l_bit;
      default:         res = (l_bit == r_bit);
    endcase
    val_cnt_nxt  = val_cnt_r;
    val_cmd.op   = bie_pkg::STK_HOLD;
    val_cmd.data = '0;
    val_flag     = bie_pkg::ST_OK;
    if (lit_en) begin
      val_cmd.data = {{(bie_pkg::OP_W-1){1'b0}}, lit_val};
      if (val_cnt_r == FULL) begin
        val_flag = bie_pkg::ST_OVERFLOW;
      end else begin
        val_cmd.op  = bie_pkg::STK_PUSH;
        val_cnt_nxt = val_cnt_r + ONE;
      end
    end else if (apply_en) begin
      val_cmd.data = {{(bie_pkg::OP_W-1){1'b0}}, res};
      if (val_cnt_r == '0) begin
        val_flag    = bie_pkg::ST_MISSING;
        val_cmd.op  = bie_pkg::STK_PUSH;
        val_cnt_nxt = ONE;
      end else if (top_op == bie_pkg::OP_NOT) begin
        val_cmd.op = bie_pkg::STK_REPL;
      end else if (val_cnt_r == ONE) begin
        val_flag   = bie_pkg::ST_MISSING;
        val_cmd.op = bie_pkg::STK_REPL;
      end else begin
        val_cmd.op  = bie_pkg::STK_POPREPL;
        val_cnt_nxt = val_cnt_r - ONE;
      end
    end
  end

  // error keep, result and clear
  always_comb begin
    flag           = fsm_flag | op_flag | val_flag;
    err_nxt        = (err_r == bie_pkg::ST_OK) ? flag : err_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = (val_cnt_r != '0) ? v0 : 1'b0;
      out_status_nxt = err_r;
      err_nxt        = bie_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      last_r      <= 1'b0;
      skip_r      <= 1'b0;
      err_r       <= bie_pkg::ST_OK;
      op_cnt_r    <= '0;
      val_cnt_r   <= '0;
      var_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      last_r      <= last_nxt;
      skip_r      <= out_load ? 1'b0 : skip_nxt;
      err_r       <= err_nxt;
      op_cnt_r    <= out_load ? '0 : op_cnt_nxt;
      val_cnt_r   <= out_load ? '0 : val_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        var_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_r       <= pend_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire
